// File: src/bcd_pkg.sv
// ----------------------------------------------------------------------------
// bcd_pkg: shared types and arithmetic for the BC1/BC2/BC3 block decoder
// Holds the format codes, the palette structures passed between modules and
// the small constant-divide helpers used to expand and blend endpoints.
// ----------------------------------------------------------------------------
package bcd_pkg;

  // Format codes of the block_format register. Code 3 decodes as BC1.
  localparam logic [1:0] FMT_BC1 = 2'd0;
  localparam logic [1:0] FMT_BC2 = 2'd1;
  localparam logic [1:0] FMT_BC3 = 2'd2;

  // Expanded color endpoints of one block and the c0 > c1 mode flag.
  typedef struct packed {
    logic [23:0] e0;
    logic [23:0] e1;
    logic        gt;
  } endpoints_t;

  // Four-entry RGBA color palette and eight-entry alpha table of one block.
  typedef struct packed {
    logic [3:0][31:0] color;
    logic [7:0][7:0]  alpha;
  } palette_t;

  // Floor of v*255/31: 8v plus floor(7v/31), the latter by reciprocal.
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [15:0] prod;
    prod = 16'(v) * 16'd1855;
    return 8'({v, 3'b000}) + 8'(prod >> 13);
  endfunction

  // Floor of v*255/63: 4v plus floor(v/21), the latter by compares.
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [1:0] q;
    if (v >= 6'd63) begin
      q = 2'd3;
    end else if (v >= 6'd42) begin
      q = 2'd2;
    end else if (v >= 6'd21) begin
      q = 2'd1;
    end else begin
      q = 2'd0;
    end
    return 8'({v, 2'b00}) + 8'(q);
  endfunction

  // RGB565 to packed 24-bit color, red in the low byte.
  function automatic logic [23:0] expand565(input logic [15:0] v);
    return {expand5(v[4:0]), expand6(v[10:5]), expand5(v[15:11])};
  endfunction

  // Floor of s/3 for s up to 765.
  function automatic logic [7:0] div3(input logic [9:0] s);
    logic [19:0] prod;
    prod = 20'(s) * 20'd683;
    return 8'(prod >> 11);
  endfunction

  // Floor of s/5 for s up to 1275.
  function automatic logic [7:0] div5(input logic [10:0] s);
    logic [21:0] prod;
    prod = 22'(s) * 22'd1639;
    return 8'(prod >> 13);
  endfunction

  // Floor of s/7 for s up to 1785.
  function automatic logic [7:0] div7(input logic [10:0] s);
    logic [22:0] prod;
    prod = 23'(s) * 23'd2341;
    return 8'(prod >> 14);
  endfunction

endpackage

// File: src/bcd_palette.sv
// ----------------------------------------------------------------------------
// bcd_palette: palette and alpha table builder
// Blends the two expanded color endpoints into the four-entry palette and
// builds the eight-entry interpolated alpha table from the two alpha ends.
// ----------------------------------------------------------------------------
module bcd_palette
  import bcd_pkg::*;
(
  input  endpoints_t  ends,
  input  logic [15:0] alpha_ends,
  output palette_t    pal
);

  // Color palette and alpha table of one block.
  always_comb begin
    logic [7:0]  x;
    logic [7:0]  y;
    logic [9:0]  s2;
    logic [9:0]  s3;
    logic [8:0]  avg;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [10:0] s;
    // Four- or three-color mode chosen by the endpoint order.
    pal.color[0] = {8'hFF, ends.e0};
    pal.color[1] = {8'hFF, ends.e1};
    pal.color[2] = {8'hFF, 24'h000000};
    pal.color[3] = ends.gt ? {8'hFF, 24'h000000} : 32'h0000_0000;
    for (int k = 0; k < 3; k++) begin
      x   = ends.e0[8*k +: 8];
      y   = ends.e1[8*k +: 8];
      s2  = {1'b0, x, 1'b0} + {2'b00, y};
      s3  = {2'b00, x} + {1'b0, y, 1'b0};
      avg = {1'b0, x} + {1'b0, y};
      if (ends.gt) begin
        pal.color[2][8*k +: 8] = div3(s2);
        pal.color[3][8*k +: 8] = div3(s3);
      end else begin
        pal.color[2][8*k +: 8] = avg[8:1];
      end
    end

    // Eight-level blend when a0 > a1, else six levels plus 0 and 255.
    a0 = alpha_ends[7:0];
    a1 = alpha_ends[15:8];
    pal.alpha[0] = a0;
    pal.alpha[1] = a1;
    for (int k = 2; k < 8; k++) begin
      if (a0 > a1) begin
        s = 11'(a0) * 11'(8 - k) + 11'(a1) * 11'(k - 1);
        pal.alpha[k] = div7(s);
      end else if (k < 6) begin
        s = 11'(a0) * 11'(6 - k) + 11'(a1) * 11'(k - 1);
        pal.alpha[k] = div5(s);
      end else begin
        s = 11'd0;
        pal.alpha[k] = (k == 6) ? 8'h00 : 8'hFF;
      end
    end
  end

endmodule

// File: src/bcd_lane.sv
// ----------------------------------------------------------------------------
// bcd_lane: one pixel column of the row decoder
// Looks up the pixel color in the block palette and replaces its alpha
// according to the block format.
// ----------------------------------------------------------------------------
module bcd_lane
  import bcd_pkg::*;
(
  input  palette_t    pal,
  input  logic [1:0]  fmt,
  input  logic [1:0]  color_idx,
  input  logic [3:0]  alpha_nib,
  input  logic [2:0]  alpha_idx,
  output logic [31:0] pixel
);

  logic [31:0] base;

  // Palette color for this pixel.
  assign base = pal.color[color_idx];

  // Alpha source per format; the unused code keeps the palette alpha.
  always_comb begin
    case (fmt)
      FMT_BC2: pixel = {alpha_nib, alpha_nib, base[23:0]};
      FMT_BC3: pixel = {pal.alpha[alpha_idx], base[23:0]};
      default: pixel = base;
    endcase
  end

endmodule

// File: src/bc_texture_block_decoder_core.sv
// ----------------------------------------------------------------------------
// bc_texture_block_decoder_core: BC1/BC2/BC3 4x4 texture block decoder
// Takes one compressed block and emits its four pixel rows, one per cycle,
// through four parallel column lanes and a registered row output.
// ----------------------------------------------------------------------------
// A block is taken when start is high and busy is low. It goes from the input
// stage to the row stage, and its rows leave through the output register on
// consecutive cycles, each shown for one cycle with strobe high; the receiver
// cannot stall. The row emitter emits a held block one row per cycle while the
// next block waits in the input stage while the current one drains. Busy is
// high during reset. block_format must be written by the user only while no
// item is in flight; the block does not enforce it.
module bc_texture_block_decoder_core
  import bcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] color_bits,
  input  logic [63:0] alpha_half,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,
  output logic        strobe,
  output logic [1:0]  row_index,
  output logic [31:0] pixel_left,
  output logic [31:0] pixel_second,
  output logic [31:0] pixel_third,
  output logic [31:0] pixel_right,
  output logic        last_row
);

  logic [1:0]  block_format;

  // Input stage: expanded endpoints, index word and alpha half.
  logic        a_valid;
  endpoints_t  a_ends;
  logic [31:0] a_index;
  logic [63:0] a_alpha;

  // Row stage: palette of the block being emitted and its row counter.
  logic        b_valid;
  logic [1:0]  b_row;
  palette_t    b_pal;
  logic [31:0] b_index;
  logic [63:0] b_alpha;

  logic        b_free;
  logic        move_ab;
  logic        accept;
  palette_t    pal_next;
  logic [7:0]  row_cidx;
  logic [15:0] row_anib;
  logic [11:0] row_aidx;
  logic [3:0][31:0] lane_px;

  // Format register.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_format <= FMT_BC1;
    end else if (cfg_we) begin
      block_format <= cfg_data;
    end
  end

  // Handshake: the row stage takes the input when idle or on its last row.
  assign b_free  = !b_valid || (b_row == 2'd3);
  assign move_ab = a_valid && b_free;
  assign busy    = rst || (a_valid && !b_free);
  assign accept  = start && !busy;

  // Input stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (move_ab) begin
      a_valid <= 1'b0;
    end
  end

  // Input stage payload, with the endpoints expanded on the way in.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_ends.e0 <= expand565(color_bits[15:0]);
      a_ends.e1 <= expand565(color_bits[31:16]);
      a_ends.gt <= color_bits[15:0] > color_bits[31:16];
      a_index   <= color_bits[63:32];
      a_alpha   <= alpha_half;
    end
  end

  // Palette and alpha table of the waiting block.
  bcd_palette u_palette (
    .ends       (a_ends),
    .alpha_ends (a_alpha[15:0]),
    .pal        (pal_next)
  );

  // Row stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_row   <= 2'd0;
    end else if (move_ab) begin
      b_valid <= 1'b1;
      b_row   <= 2'd0;
    end else if (b_valid) begin
      b_row <= b_row + 2'd1;
      if (b_row == 2'd3) begin
        b_valid <= 1'b0;
      end
    end
  end

  // Row stage payload.
  always_ff @(posedge clk) begin
    if (move_ab) begin
      b_pal   <= pal_next;
      b_index <= a_index;
      b_alpha <= a_alpha;
    end
  end

  // Index fields of the current row.
  assign row_cidx = b_index[8*b_row +: 8];
  assign row_anib = b_alpha[16*b_row +: 16];
  assign row_aidx = b_alpha[16 + 12*b_row +: 12];

  // Column lanes.
  for (genvar x = 0; x < 4; x++) begin : g_lane
    bcd_lane u_lane (
      .pal       (b_pal),
      .fmt       (block_format),
      .color_idx (row_cidx[2*x +: 2]),
      .alpha_nib (row_anib[4*x +: 4]),
      .alpha_idx (row_aidx[3*x +: 3]),
      .pixel     (lane_px[x])
    );
  end

  // Output register: merges the lane pixels into one row item.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    row_index    <= b_row;
    last_row     <= b_row == 2'd3;
    pixel_left   <= lane_px[0];
    pixel_second <= lane_px[1];
    pixel_third  <= lane_px[2];
    pixel_right  <= lane_px[3];
  end

`ifndef ASSERT_OFF
  // The last-row flag marks exactly the fourth row.
  assert property (@(posedge clk) disable iff (rst)
    strobe |-> (last_row == (row_index == 2'd3)))
    else $error("last_row does not match row_index");

  // Rows of one block leave on consecutive cycles in order.
  assert property (@(posedge clk) disable iff (rst)
    (strobe && row_index != 2'd3) |=>
      (strobe && row_index == 2'($past(row_index) + 2'd1)))
    else $error("row sequence broken");

  // An accepted item is held in the input stage.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> a_valid)
    else $error("accepted item lost");

  // Busy only while the row stage is still emitting an earlier block.
  assert property (@(posedge clk) disable iff (rst)
    busy |-> (b_valid && b_row != 2'd3))
    else $error("busy without a draining block");
`endif

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the BC1/BC2/BC3 texture block decoder
// Feeds compressed 4x4 blocks under every format code and predicts the four
// RGBA rows of each block. Every row on the strobe is checked field by field.
// ----------------------------------------------------------------------------
module tb;
  import bcd_pkg::*;

  localparam logic [1:0] FMT_SPARE = 2'd3;   // unused code, decodes as BC1
  localparam int ROWS_PER_BLOCK   = 4;
  localparam int SETTLE_CYCLES    = 6;
  localparam int TAIL_CYCLES      = 16;
  localparam int LIMIT_CYCLES     = 60000;
  localparam int PHASE_BLOCKS     = 26;

  // Endpoint orderings asked of the random color generator.
  localparam int MODE_ANY   = 0;
  localparam int MODE_FOUR  = 1;
  localparam int MODE_THREE = 2;
  localparam int MODE_EQUAL = 3;

  typedef enum logic [1:0] {OP_BLOCK, OP_CONFIG, OP_DRAIN} op_kind_t;

  typedef struct {
    op_kind_t    kind;
    logic [63:0] color;
    logic [63:0] alpha;
    int unsigned gap;
    logic [1:0]  fmt;
  } bench_op_t;

  typedef struct packed {
    logic [1:0]       row;
    logic [3:0][31:0] px;
    logic             last;
  } pixel_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] color_bits = '0;
  logic [63:0] alpha_half = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_data = FMT_BC1;
  logic        strobe;
  logic [1:0]  row_index;
  logic [31:0] pixel_left;
  logic [31:0] pixel_second;
  logic [31:0] pixel_third;
  logic [31:0] pixel_right;
  logic        last_row;

  bench_op_t   pending[$];
  pixel_row_t  rows_due[$];
  int unsigned errors = 0;
  int unsigned blocks_taken = 0;
  int unsigned rows_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned blocks_per_fmt[4] = '{0, 0, 0, 0};
  int unsigned cycles = 0;

  bc_texture_block_decoder_core u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .color_bits   (color_bits),
    .alpha_half   (alpha_half),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .strobe       (strobe),
    .row_index    (row_index),
    .pixel_left   (pixel_left),
    .pixel_second (pixel_second),
    .pixel_third  (pixel_third),
    .pixel_right  (pixel_right),
    .last_row     (last_row)
  );

  always #2 clk = ~clk;

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // A run that hangs is a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("** bc_texture_block_decoder_core: FAILED **");
      $finish;
    end
  end

  // Scale an n-bit channel to 0..255 with truncation.
  function automatic int unsigned widen(input int unsigned v, input int unsigned top);
    return v * 255 / top;
  endfunction

  // Decode one block into its four expected rows and queue them.
  function automatic void decode_block(input logic [63:0] cb, input logic [63:0] ab,
                                       input logic [1:0] fmt);
    int unsigned      c0, c1, x, y, a0, a1, p;
    logic [7:0]       ch0[3];
    logic [7:0]       ch1[3];
    logic [3:0][31:0] pal;
    logic [7:0]       atab[8];
    logic [31:0]      pix;
    logic [1:0]       ci;
    pixel_row_t       r;
    c0 = 32'(cb[15:0]);
    c1 = 32'(cb[31:16]);
    ch0[0] = 8'(widen((c0 >> 11) & 'h1F, 31));
    ch0[1] = 8'(widen((c0 >> 5) & 'h3F, 63));
    ch0[2] = 8'(widen(c0 & 'h1F, 31));
    ch1[0] = 8'(widen((c1 >> 11) & 'h1F, 31));
    ch1[1] = 8'(widen((c1 >> 5) & 'h3F, 63));
    ch1[2] = 8'(widen(c1 & 'h1F, 31));
    pal[0] = {8'hFF, ch0[2], ch0[1], ch0[0]};
    pal[1] = {8'hFF, ch1[2], ch1[1], ch1[0]};
    pal[2] = 32'hFF00_0000;
    pal[3] = (c0 > c1) ? 32'hFF00_0000 : 32'h0;
    for (int k = 0; k < 3; k++) begin
      x = 32'(ch0[k]);
      y = 32'(ch1[k]);
      if (c0 > c1) begin
        pal[2][8*k +: 8] = 8'((2 * x + y) / 3);
        pal[3][8*k +: 8] = 8'((x + 2 * y) / 3);
      end else begin
        pal[2][8*k +: 8] = 8'((x + y) / 2);
      end
    end

    // Interpolated alpha: seven steps, or five steps plus hard 0 and 255.
    a0 = 32'(ab[7:0]);
    a1 = 32'(ab[15:8]);
    atab[0] = 8'(a0);
    atab[1] = 8'(a1);
    if (a0 > a1) begin
      for (int k = 2; k < 8; k++) atab[k] = 8'(((8 - k) * a0 + (k - 1) * a1) / 7);
    end else begin
      for (int k = 2; k < 6; k++) atab[k] = 8'(((6 - k) * a0 + (k - 1) * a1) / 5);
      atab[6] = 8'd0;
      atab[7] = 8'd255;
    end

    for (int row = 0; row < ROWS_PER_BLOCK; row++) begin
      r.row  = 2'(row);
      r.last = (row == ROWS_PER_BLOCK - 1);
      for (int col = 0; col < 4; col++) begin
        p   = 4 * row + col;
        ci  = cb[32 + 2 * p +: 2];
        pix = pal[ci];
        case (fmt)
          FMT_BC2: begin
            pix[31:24] = 8'(widen(32'(ab[4 * p +: 4]), 15));
          end
          FMT_BC3: begin
            pix[31:24] = atab[ab[16 + 3 * p +: 3]];
          end
          default: begin
          end
        endcase
        r.px[col] = pix;
      end
      rows_due.push_back(r);
    end
  endfunction

  function automatic void compare_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, field, want, got);
      errors++;
    end
  endfunction

  // Driver: presents queued blocks, format writes and drain points.
  always @(posedge clk) begin : driver
    bench_op_t   op;
    logic        go;
    logic        we_next;
    int unsigned idle_run;
    int unsigned quiet;
    int unsigned rows_owed;
    if (rst) begin
      start      <= 1'b0;
      cfg_we     <= 1'b0;
      cfg_data   <= FMT_BC1;
      color_bits <= '0;
      alpha_half <= '0;
      idle_run   = 0;
      quiet      = 0;
      rows_owed  = 0;
    end else begin
      go      = start;
      we_next = 1'b0;
      if (start && !busy) begin
        rows_owed += ROWS_PER_BLOCK;
        go       = 1'b0;
        idle_run = 0;
      end
      if (strobe && rows_owed != 0) rows_owed--;
      quiet = (rows_owed == 0 && !go) ? quiet + 1 : 0;

      if (!go && pending.size() != 0) begin
        op = pending[0];
        case (op.kind)
          OP_BLOCK: begin
            if (idle_run >= op.gap) begin
              color_bits <= op.color;
              alpha_half <= op.alpha;
              go = 1'b1;
              void'(pending.pop_front());
            end
          end
          OP_CONFIG: begin
            if (quiet >= SETTLE_CYCLES) begin
              we_next = 1'b1;
              cfg_data <= op.fmt;
              quiet = 0;
              void'(pending.pop_front());
            end
          end
          default: begin
            if (quiet >= SETTLE_CYCLES) void'(pending.pop_front());
          end
        endcase
      end
      if (!go) idle_run++;
      start  <= go;
      cfg_we <= we_next;
    end
  end

  // Monitor: tracks the format, predicts accepted blocks and checks rows.
  always @(posedge clk) begin : monitor
    logic [1:0] fmt_now;
    pixel_row_t want;
    if (rst) begin
      fmt_now = FMT_BC1;
    end else begin
      if (cfg_we) begin
        fmt_now = cfg_data;
        cfg_writes++;
      end
      if (start && !busy) begin
        decode_block(color_bits, alpha_half, fmt_now);
        blocks_taken++;
        blocks_per_fmt[fmt_now]++;
      end
      if (strobe) begin
        if (rows_due.size() == 0) begin
          $display("%0t: expected no row, got row %0d", $time, row_index);
          errors++;
        end else begin
          want = rows_due.pop_front();
          compare_field("row_index", 32'(want.row), 32'(row_index));
          compare_field("pixel_left", want.px[0], pixel_left);
          compare_field("pixel_second", want.px[1], pixel_second);
          compare_field("pixel_third", want.px[2], pixel_third);
          compare_field("pixel_right", want.px[3], pixel_right);
          compare_field("last_row", 32'(want.last), 32'(last_row));
          rows_checked++;
        end
      end
    end
  end

  function automatic void add_block(input logic [63:0] color, input logic [63:0] alpha,
                                    input int unsigned gap);
    bench_op_t op;
    op.kind  = OP_BLOCK;
    op.color = color;
    op.alpha = alpha;
    op.gap   = gap;
    op.fmt   = FMT_BC1;
    pending.push_back(op);
  endfunction

  function automatic void add_marker(input op_kind_t kind, input logic [1:0] fmt);
    bench_op_t op;
    op.kind  = kind;
    op.color = '0;
    op.alpha = '0;
    op.gap   = 0;
    op.fmt   = fmt;
    pending.push_back(op);
  endfunction

  // Random color half with the requested endpoint ordering.
  function automatic logic [63:0] random_color(input int unsigned mode);
    logic [63:0] c;
    logic [15:0] t;
    c = {$urandom, $urandom};
    case (mode)
      MODE_FOUR: begin
        if (c[15:0] == c[31:16]) c[0] = ~c[0];
        if (c[15:0] < c[31:16]) begin
          t = c[15:0];
          c[15:0] = c[31:16];
          c[31:16] = t;
        end
      end
      MODE_THREE: begin
        if (c[15:0] > c[31:16]) begin
          t = c[15:0];
          c[15:0] = c[31:16];
          c[31:16] = t;
        end
      end
      MODE_EQUAL: begin
        c[31:16] = c[15:0];
      end
      default: begin
      end
    endcase
    return c;
  endfunction

  // Alpha half whose per-pixel indices walk through all eight table entries.
  function automatic logic [63:0] alpha_ramp(input logic [7:0] a0, input logic [7:0] a1);
    logic [63:0] a;
    a = {$urandom, $urandom};
    a[7:0]  = a0;
    a[15:8] = a1;
    for (int p = 0; p < 16; p++) a[16 + 3 * p +: 3] = 3'(p);
    return a;
  endfunction

  // Stimulus: directed corners per format, then random phases.
  initial begin : stimulus
    logic [1:0]  phase_fmt[8];
    int unsigned gap;
    phase_fmt = '{FMT_BC3, FMT_BC1, FMT_BC2, FMT_SPARE, FMT_BC3, FMT_BC2, FMT_BC1, FMT_BC3};

    // BC1 from reset: zero block, all ones, extreme endpoints in both orders.
    add_block(64'h0, 64'h0, 0);
    add_block({64{1'b1}}, {64{1'b1}}, 0);
    add_block({32'hE4E4_E4E4, 16'h0000, 16'hFFFF}, 64'h0, 1);
    add_block({32'hE4E4_E4E4, 16'hFFFF, 16'h0000}, 64'h0, 0);
    add_block({$urandom, 16'h07E0, 16'hF81F}, {$urandom, $urandom}, 2);

    // Explicit alpha: every nibble value, zero and full alpha, transparent black.
    add_marker(OP_CONFIG, FMT_BC2);
    add_block({32'hE4E4_E4E4, 16'h001F, 16'hF800}, 64'hFEDC_BA98_7654_3210, 0);
    add_block({32'hFFFF_FFFF, 16'hFFE0, 16'h001F}, 64'h0, 0);
    add_block({32'h1B1B_1B1B, 16'h0000, 16'hFFFF}, {64{1'b1}}, 3);

    // Interpolated alpha: both table modes, equal endpoints, saturated table.
    add_marker(OP_CONFIG, FMT_BC3);
    add_block({32'hE4E4_E4E4, 16'h0000, 16'hFFFF}, alpha_ramp(8'hFF, 8'h00), 0);
    add_block({32'hE4E4_E4E4, 16'hFFFF, 16'h0000}, alpha_ramp(8'h00, 8'hFF), 0);
    add_block(random_color(MODE_ANY), alpha_ramp(8'h80, 8'h80), 1);
    add_block(random_color(MODE_FOUR), alpha_ramp(8'hF0, 8'h10), 0);
    add_block(random_color(MODE_THREE), {64{1'b1}}, 0);

    // The spare format code ignores the alpha half.
    add_marker(OP_CONFIG, FMT_SPARE);
    add_block(random_color(MODE_FOUR), {64{1'b1}}, 0);

    // Random phases, each under one format, with a full drain in some of them.
    for (int ph = 0; ph < 8; ph++) begin
      add_marker(OP_CONFIG, phase_fmt[ph]);
      for (int i = 0; i < PHASE_BLOCKS; i++) begin
        gap = (i % 10 < 4) ? 0 : $urandom_range(0, 5);
        add_block(random_color($urandom_range(MODE_ANY, MODE_EQUAL)),
                  {$urandom, $urandom}, gap);
        if (i == PHASE_BLOCKS / 2 && (ph == 2 || ph == 5)) begin
          add_marker(OP_DRAIN, FMT_BC1);
        end
      end
    end

    while (rst) @(negedge clk);
    while (pending.size() != 0 || start || rows_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (rows_due.size() != 0) begin
      $display("%0t: %0d expected rows never arrived", $time, rows_due.size());
      errors++;
    end

    $display("Decoded %0d blocks (%0d rows checked), %0d format writes.",
             blocks_taken, rows_checked, cfg_writes);
    $display("Blocks per format code: BC1 %0d, BC2 %0d, BC3 %0d, spare %0d; %0d errors.",
             blocks_per_fmt[FMT_BC1], blocks_per_fmt[FMT_BC2], blocks_per_fmt[FMT_BC3],
             blocks_per_fmt[FMT_SPARE], errors);
    if (errors == 0) begin
      $display("** bc_texture_block_decoder_core: PASSED **");
    end else begin
      $display("** bc_texture_block_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule
